FILE: hw/rtl/md5_password_search_core_defines.svh
// Assertion macros shared by the password search RTL.
`ifndef MD5_PASSWORD_SEARCH_CORE_DEFINES_SVH
`define MD5_PASSWORD_SEARCH_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked property, gated off while reset is asserted
`define MD5PS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("md5ps assertion failed");
// Checked property, also evaluated during reset
`define MD5PS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("md5ps assertion failed");
`else
`define MD5PS_ASSERT(lbl, prop)
`define MD5PS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hw/rtl/md5ps_pkg.sv
// Shared types, constants and helper functions for the MD5 password search.
`timescale 1ns / 1ps
package md5ps_pkg;

    localparam int IDX_W       = 19;
    localparam int MASK_W      = 4;
    localparam int NUM_REGS    = 8;
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam int MD5_ROUNDS  = 64;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5_state_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [31:0] MD5_K [MD5_ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amount per round, four per quarter
    function automatic int md5_shift(input int rnd);
        int q;
        int s;
        q = rnd / 16;
        s = 0;
        unique case (q)
            0: s = (rnd % 4 == 0) ? 7 : (rnd % 4 == 1) ? 12 : (rnd % 4 == 2) ? 17 : 22;
            1: s = (rnd % 4 == 0) ? 5 : (rnd % 4 == 1) ? 9  : (rnd % 4 == 2) ? 14 : 20;
            2: s = (rnd % 4 == 0) ? 4 : (rnd % 4 == 1) ? 11 : (rnd % 4 == 2) ? 16 : 23;
            default: s = (rnd % 4 == 0) ? 6 : (rnd % 4 == 1) ? 10 : (rnd % 4 == 2) ? 15 : 21;
        endcase
        return s;
    endfunction

    // Message word used by each round
    function automatic int md5_msg_index(input int rnd);
        int g;
        if (rnd < 16)
            g = rnd;
        else if (rnd < 32)
            g = (5 * rnd + 1) % 16;
        else if (rnd < 48)
            g = (3 * rnd + 5) % 16;
        else
            g = (7 * rnd) % 16;
        return g;
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

FILE: hw/rtl/md5ps_digits.sv
// Pipelined base conversion of the candidate index into password letters.
`timescale 1ns / 1ps
module md5ps_digits #(
    parameter int PASSWORD_LEN  = 4,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [md5ps_pkg::IDX_W-1:0]   in_idx,
    output logic                          out_valid,
    output logic [md5ps_pkg::IDX_W-1:0]   out_idx,
    output logic [8*PASSWORD_LEN-1:0]     out_pw
);
    import md5ps_pkg::*;

    localparam int PW_W   = 8 * PASSWORD_LEN;
    localparam int PROD_W = IDX_W + 32;
    // floor(2^32 / A): quotient estimate is low by at most one for 19-bit values
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / ALPHABET_SIZE);
    localparam logic [IDX_W-1:0] RADIX = IDX_W'(ALPHABET_SIZE);

    logic             ch_valid [PASSWORD_LEN+1];
    logic [IDX_W-1:0] ch_v     [PASSWORD_LEN+1];
    logic [IDX_W-1:0] ch_idx   [PASSWORD_LEN+1];
    logic [PW_W-1:0]  ch_pw    [PASSWORD_LEN+1];

    assign ch_valid[0] = in_valid;
    assign ch_v[0]     = in_idx;
    assign ch_idx[0]   = in_idx;
    assign ch_pw[0]    = '0;

    // Two stages per letter: reciprocal multiply, then remainder and correction
    for (genvar k = 0; k < PASSWORD_LEN; k++) begin : g_digit
        logic              mul_valid_reg;
        logic [PROD_W-1:0] mul_prod_reg;
        logic [IDX_W-1:0]  mul_v_reg;
        logic [IDX_W-1:0]  mul_idx_reg;
        logic [PW_W-1:0]   mul_pw_reg;
        logic              rem_valid_reg;
        logic [IDX_W-1:0]  rem_q_reg;
        logic [IDX_W-1:0]  rem_idx_reg;
        logic [PW_W-1:0]   rem_pw_reg;
        logic [IDX_W-1:0]  q_est;
        logic [IDX_W-1:0]  r_est;
        logic [IDX_W-1:0]  q_next;
        logic [IDX_W-1:0]  r_fix;
        logic [PW_W-1:0]   pw_next;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mul_valid_reg <= 1'b0;
                rem_valid_reg <= 1'b0;
            end
            else if (en)
            begin
                mul_valid_reg <= ch_valid[k];
                rem_valid_reg <= mul_valid_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mul_prod_reg <= PROD_W'(ch_v[k]) * PROD_W'(RECIP);
                mul_v_reg    <= ch_v[k];
                mul_idx_reg  <= ch_idx[k];
                mul_pw_reg   <= ch_pw[k];
                rem_q_reg    <= q_next;
                rem_idx_reg  <= mul_idx_reg;
                rem_pw_reg   <= pw_next;
            end
        end

        // Remainder with one correction step
        always_comb
        begin
            q_est   = mul_prod_reg[PROD_W-1:32];
            r_est   = mul_v_reg - IDX_W'(q_est * RADIX);
            q_next  = q_est;
            r_fix   = r_est;
            if (r_est >= RADIX)
            begin
                q_next = q_est + 1'b1;
                r_fix  = r_est - RADIX;
            end
            pw_next = mul_pw_reg;
            pw_next[8*(PASSWORD_LEN-1-k) +: 8] = 8'd97 + r_fix[7:0];
        end

        assign ch_valid[k+1] = rem_valid_reg;
        assign ch_v[k+1]     = rem_q_reg;
        assign ch_idx[k+1]   = rem_idx_reg;
        assign ch_pw[k+1]    = rem_pw_reg;
    end

    assign out_valid = ch_valid[PASSWORD_LEN];
    assign out_idx   = ch_idx[PASSWORD_LEN];
    assign out_pw    = ch_pw[PASSWORD_LEN];

endmodule

FILE: hw/rtl/md5ps_round.sv
// One registered MD5 round stage with its message word built from the password.
`timescale 1ns / 1ps
module md5ps_round #(
    parameter int ROUND        = 0,
    parameter int PASSWORD_LEN = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  md5ps_pkg::md5_state_t         in_st,
    input  logic [8*PASSWORD_LEN-1:0]     in_pw,
    input  logic [md5ps_pkg::IDX_W-1:0]   in_idx,
    output logic                          out_valid,
    output md5ps_pkg::md5_state_t         out_st,
    output logic [8*PASSWORD_LEN-1:0]     out_pw,
    output logic [md5ps_pkg::IDX_W-1:0]   out_idx
);
    import md5ps_pkg::*;

    localparam int          G     = md5_msg_index(ROUND);
    localparam int          S     = md5_shift(ROUND);
    localparam logic [31:0] KC    = MD5_K[ROUND];
    localparam logic [7:0]  BITS  = 8'(8 * PASSWORD_LEN);

    logic             valid_reg;
    md5_state_t       st_reg;
    logic [8*PASSWORD_LEN-1:0] pw_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [31:0]      m_word;
    logic [31:0]      f_val;
    logic [31:0]      sum;
    logic [31:0]      rot;
    md5_state_t       st_next;

    // Padded block bytes: password, 0x80, zeros, bit length at byte 56
    for (genvar j = 0; j < 4; j++) begin : g_byte
        localparam int P = 4 * G + j;
        if (P < PASSWORD_LEN) begin : g_pw
            assign m_word[8*j +: 8] = in_pw[8*P +: 8];
        end
        else if (P == PASSWORD_LEN) begin : g_pad
            assign m_word[8*j +: 8] = 8'h80;
        end
        else if (P == 56) begin : g_len
            assign m_word[8*j +: 8] = BITS;
        end
        else begin : g_zero
            assign m_word[8*j +: 8] = 8'h00;
        end
    end

    // Round function and state update
    always_comb
    begin
        if (ROUND < 16)
            f_val = (in_st.b & in_st.c) | (~in_st.b & in_st.d);
        else if (ROUND < 32)
            f_val = (in_st.d & in_st.b) | (~in_st.d & in_st.c);
        else if (ROUND < 48)
            f_val = in_st.b ^ in_st.c ^ in_st.d;
        else
            f_val = in_st.c ^ (in_st.b | ~in_st.d);
        sum       = in_st.a + f_val + KC + m_word;
        rot       = (sum << S) | (sum >> (32 - S));
        st_next.a = in_st.d;
        st_next.b = in_st.b + rot;
        st_next.c = in_st.b;
        st_next.d = in_st.c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg  <= st_next;
            pw_reg  <= in_pw;
            idx_reg <= in_idx;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;
    assign out_pw    = pw_reg;
    assign out_idx   = idx_reg;

endmodule

FILE: hw/rtl/md5_password_search_core.sv
// Top level of the pipelined MD5 password search with its target registers.
//
// Input channel: candidate_index with in_valid/in_ready; one transfer per candidate.
// Output channel: index_out, match_mask and found with out_valid/out_ready; exactly
// one result transfer per input transfer, in order.
// The index is split into PASSWORD_LEN letters ('a' + base-ALPHABET_SIZE digit),
// hashed as one padded MD5 block and compared with up to four target digests.
// From input transfer to out_valid a candidate passes the digit stages (two per
// letter), 64 round stages, the finalize stage and the compare/output stage.
// Throughput: one candidate per cycle while not stalled; each round stage holds one MD5 round.
// Targets are written over the APB port at byte address 8*i (64-bit data);
// writes are meant while no candidate is in flight. Reads return the register.
// Reset clears all valid bits and the targets to zero.
// When the receiver stalls, the whole pipeline holds and in_ready drops in the
// same cycle; nothing is lost or repeated, and bubbles in flight stay put.
`timescale 1ns / 1ps
`include "md5_password_search_core_defines.svh"
module md5_password_search_core #(
    parameter int PASSWORD_LEN  = 4,
    parameter int ALPHABET_SIZE = 26,
    parameter int NUM_TARGETS   = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [md5ps_pkg::IDX_W-1:0]     candidate_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [md5ps_pkg::IDX_W-1:0]     index_out,
    output logic [md5ps_pkg::MASK_W-1:0]    match_mask,
    output logic                            found,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [md5ps_pkg::ADDR_W-1:0]    paddr,
    input  logic [md5ps_pkg::DATA_W-1:0]    pwdata,
    output logic [md5ps_pkg::DATA_W-1:0]    prdata,
    output logic                            pready
);
    import md5ps_pkg::*;

    localparam int PW_W = 8 * PASSWORD_LEN;

    logic              en;
    logic [DATA_W-1:0] target_reg [NUM_REGS];

    logic              rd_valid [MD5_ROUNDS+1];
    md5_state_t        rd_st    [MD5_ROUNDS+1];
    logic [PW_W-1:0]   rd_pw    [MD5_ROUNDS+1];
    logic [IDX_W-1:0]  rd_idx   [MD5_ROUNDS+1];

    logic              fin_valid_reg;
    logic [127:0]      fin_digest_reg;
    logic [IDX_W-1:0]  fin_idx_reg;
    logic [127:0]      digest_next;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [MASK_W-1:0] out_mask_reg;
    logic              out_found_reg;
    logic [MASK_W-1:0] mask_next;

    // Global advance: the output register is free or being drained
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                target_reg[i] <= '0;
        end
        else if (psel && penable && pwrite)
            target_reg[paddr[5:3]] <= pwdata;
    end

    assign prdata = target_reg[paddr[5:3]];
    assign pready = 1'b1;

    // Letter extraction
    md5ps_digits #(
        .PASSWORD_LEN  (PASSWORD_LEN),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_digits (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_idx    (candidate_index),
        .out_valid (rd_valid[0]),
        .out_idx   (rd_idx[0]),
        .out_pw    (rd_pw[0])
    );

    assign rd_st[0] = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};

    // 64 round stages
    for (genvar r = 0; r < MD5_ROUNDS; r++) begin : g_round
        md5ps_round #(
            .ROUND        (r),
            .PASSWORD_LEN (PASSWORD_LEN)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (rd_valid[r]),
            .in_st     (rd_st[r]),
            .in_pw     (rd_pw[r]),
            .in_idx    (rd_idx[r]),
            .out_valid (rd_valid[r+1]),
            .out_st    (rd_st[r+1]),
            .out_pw    (rd_pw[r+1]),
            .out_idx   (rd_idx[r+1])
        );
    end

    // Finalize: add chaining values, reorder into digest byte order
    assign digest_next = {bswap32(IV_A + rd_st[MD5_ROUNDS].a),
                          bswap32(IV_B + rd_st[MD5_ROUNDS].b),
                          bswap32(IV_C + rd_st[MD5_ROUNDS].c),
                          bswap32(IV_D + rd_st[MD5_ROUNDS].d)};

    // Target compare; high word is digest bytes 0..7
    always_comb
    begin
        mask_next = '0;
        for (int t = 0; t < MASK_W; t++)
        begin
            if (t < NUM_TARGETS)
                mask_next[t] = (fin_digest_reg[127:64] == target_reg[2*t+1]) &&
                               (fin_digest_reg[63:0]   == target_reg[2*t]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_valid_reg <= rd_valid[MD5_ROUNDS];
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_digest_reg <= digest_next;
            fin_idx_reg    <= rd_idx[MD5_ROUNDS];
            out_idx_reg    <= fin_idx_reg;
            out_mask_reg   <= mask_next;
            out_found_reg  <= |mask_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign index_out  = out_idx_reg;
    assign match_mask = out_mask_reg;
    assign found      = out_found_reg;

    // Checks
    `MD5PS_ASSERT(a_stall_blocks_input, (out_valid && !out_ready) |-> !in_ready)
    `MD5PS_ASSERT(a_found_matches_mask, out_valid |-> (found == (match_mask != '0)))
    `MD5PS_ASSERT(a_unused_targets_quiet, out_valid |-> ((match_mask >> NUM_TARGETS) == '0))
    `MD5PS_ASSERT_ALWAYS(a_reset_no_output, !rst_n |-> !out_valid)

endmodule
